### rtl/tspl_pkg.sv
// ----------------------------------------------------------------------------
// tspl_pkg
// Shared widths and configuration register indexes for the two-stage
// pattern locator.
// ----------------------------------------------------------------------------
package tspl_pkg;

    localparam int BYTE_W    = 8;   // message byte
    localparam int PAT_W     = 64;  // pattern register, eight bytes
    localparam int LEN_W     = 4;   // pattern length register
    localparam int OFF_W     = 16;  // reported offsets
    localparam int CFG_IDX_W = 2;   // configuration register index

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_PATTERN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBPHASE_PATTERN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBPHASE_LENGTH  = 2'd3;

endpackage

### rtl/tspl_window_match.sv
// ----------------------------------------------------------------------------
// tspl_window_match
// Parallel compare of the byte window against one pattern of a given length.
// ----------------------------------------------------------------------------
module tspl_window_match #(
    parameter int MAX_PATTERN = 8
) (
    input  logic [tspl_pkg::BYTE_W-1:0] win     [MAX_PATTERN],
    input  logic [tspl_pkg::PAT_W-1:0]  pattern,
    input  logic [tspl_pkg::LEN_W-1:0]  len,
    output logic                        hit
);
    import tspl_pkg::*;

    logic [MAX_PATTERN:0] len_hit;

    // One candidate per length: pattern byte i sits at window slot len-1-i.
    always_comb begin
        len_hit    = '1;
        for (int l = 1; l <= MAX_PATTERN; l++) begin
            for (int i = 0; i < l; i++) begin
                if (win[l-1-i] != pattern[i*BYTE_W +: BYTE_W]) begin
                    len_hit[l] = 1'b0;
                end
            end
        end
    end

    // Select the candidate for the requested length.
    always_comb begin
        hit = 1'b0;
        for (int l = 0; l <= MAX_PATTERN; l++) begin
            if (len == LEN_W'(l)) begin
                hit = len_hit[l];
            end
        end
    end

endmodule

### rtl/two_stage_pattern_locator.sv
// Path: bytes are matched out of the input register; a last byte loads the
//   result register. Throughput: one byte per cycle, a last byte waiting
//   while the result register is full; the window compare for both patterns
//   is a single parallel stage between the input and result registers.
// Reset: aresetn (synchronous, active low) clears the configuration registers,
//   the message counter and match flags, and both valid flags.
// ----------------------------------------------------------------------------
// two_stage_pattern_locator
// Streams the bytes of a message, finds the first phase pattern and then the
// first subphase pattern that starts at or after the end of the phase, and
// reports one result item on the last byte of each message.
// ----------------------------------------------------------------------------
module two_stage_pattern_locator #(
    parameter int MAX_PATTERN = 8,
    parameter int MAX_MESSAGE = 65535
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    // Configuration write port
    input  logic                           cfg_wr_en,
    input  logic [tspl_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [tspl_pkg::PAT_W-1:0]     cfg_wr_data,

    // Input byte channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [tspl_pkg::BYTE_W-1:0]    s_src_byte,
    input  logic                           s_last,

    // Result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_found,
    output logic [tspl_pkg::OFF_W-1:0]     m_phase_offset,
    output logic [tspl_pkg::OFF_W-1:0]     m_subphase_end
);
    import tspl_pkg::*;

    // Byte counter saturates one above the message limit.
    localparam int CNT_W = $clog2(MAX_MESSAGE + 2);
    // Wide enough for start + phase length + subphase length and the count.
    localparam int CMP_W = OFF_W + 2;

    localparam logic [CNT_W-1:0] MSG_MAX = CNT_W'(MAX_MESSAGE);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PAT_W-1:0] phase_pat_reg;
    logic [LEN_W-1:0] phase_len_reg;
    logic [PAT_W-1:0] sub_pat_reg;
    logic [LEN_W-1:0] sub_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_pat_reg <= '0;
            phase_len_reg <= '0;
            sub_pat_reg   <= '0;
            sub_len_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_PHASE_PATTERN:    phase_pat_reg <= cfg_wr_data;
                CFG_PHASE_LENGTH:     phase_len_reg <= cfg_wr_data[LEN_W-1:0];
                CFG_SUBPHASE_PATTERN: sub_pat_reg   <= cfg_wr_data;
                CFG_SUBPHASE_LENGTH:  sub_len_reg   <= cfg_wr_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic              out_free;
    logic              advance;
    logic              res_load;

    // The result register is free if empty or being drained this cycle.
    assign out_free = !m_valid || m_ready;
    // A byte that is not last never needs the result register.
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign res_load = advance && in_last_reg;
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_src_byte;
            in_last_reg <= s_last;
        end
    end

    // ------------------------------------------------------------------
    // Message state
    // ------------------------------------------------------------------
    // The window needs no clear: a match is only taken once the count
    // covers the whole pattern, so stale bytes never decide a match.
    logic [BYTE_W-1:0] win_reg [MAX_PATTERN];
    logic [BYTE_W-1:0] win_next [MAX_PATTERN];
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              phase_hit_reg;
    logic              phase_hit_next;
    logic [OFF_W-1:0]  phase_start_reg;
    logic [OFF_W-1:0]  phase_start_next;
    logic              sub_hit_reg;
    logic              sub_hit_next;
    logic [OFF_W-1:0]  sub_end_reg;
    logic [OFF_W-1:0]  sub_end_next;

    // Shift the new byte into slot 0.
    always_comb begin
        win_next[0] = in_byte_reg;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            win_next[k] = win_reg[k-1];
        end
    end

    // Clamp oversized lengths to the window depth.
    logic [LEN_W-1:0] plen;
    logic [LEN_W-1:0] slen;
    assign plen = (phase_len_reg > LEN_MAX) ? LEN_MAX : phase_len_reg;
    assign slen = (sub_len_reg   > LEN_MAX) ? LEN_MAX : sub_len_reg;

    logic phase_match;
    logic sub_match;

    tspl_window_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_phase_match (
        .win     (win_next),
        .pattern (phase_pat_reg),
        .len     (plen),
        .hit     (phase_match)
    );

    tspl_window_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_sub_match (
        .win     (win_next),
        .pattern (sub_pat_reg),
        .len     (slen),
        .hit     (sub_match)
    );

    logic             in_range;
    logic [CMP_W-1:0] n_ext;
    logic [CMP_W-1:0] sub_floor;
    logic             phase_take;
    logic             sub_take;

    // Count this byte, saturating past the limit.
    assign cnt_next = (cnt_reg <= MSG_MAX) ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign in_range = (cnt_next <= MSG_MAX);
    assign n_ext    = CMP_W'(cnt_next);

    // Earliest count at which a subphase may end: phase end plus its length.
    assign sub_floor = CMP_W'(phase_start_reg) + CMP_W'(plen) + CMP_W'(slen);

    assign phase_take = in_range && (plen != '0) && !phase_hit_reg
                     && (n_ext >= CMP_W'(plen)) && phase_match;

    // The subphase only starts looking on the byte after the phase hit.
    assign sub_take = in_range && (plen != '0) && phase_hit_reg && !sub_hit_reg
                   && (slen != '0) && (n_ext >= sub_floor) && sub_match;

    always_comb begin
        phase_hit_next   = phase_hit_reg;
        phase_start_next = phase_start_reg;
        sub_hit_next     = sub_hit_reg;
        sub_end_next     = sub_end_reg;
        if (phase_take) begin
            phase_hit_next   = 1'b1;
            phase_start_next = OFF_W'(n_ext - CMP_W'(plen));
        end
        if (sub_take) begin
            sub_hit_next = 1'b1;
            sub_end_next = OFF_W'(cnt_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            phase_hit_reg <= 1'b0;
            sub_hit_reg   <= 1'b0;
        end else if (advance) begin
            // Clear the count and hit flags after the last byte.
            if (in_last_reg) begin
                cnt_reg       <= '0;
                phase_hit_reg <= 1'b0;
                sub_hit_reg   <= 1'b0;
            end else begin
                cnt_reg       <= cnt_next;
                phase_hit_reg <= phase_hit_next;
                sub_hit_reg   <= sub_hit_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            win_reg         <= win_next;
            phase_start_reg <= phase_start_next;
            sub_end_reg     <= sub_end_next;
        end
    end

    // ------------------------------------------------------------------
    // Result decision
    // ------------------------------------------------------------------
    logic             res_found;
    logic [OFF_W-1:0] res_offset;
    logic [OFF_W-1:0] res_end;

    always_comb begin
        res_found  = 1'b0;
        res_offset = '0;
        res_end    = '0;
        if (in_range) begin
            if (plen == '0) begin
                // No phase configured: accept the whole message.
                res_found = 1'b1;
                res_end   = OFF_W'(cnt_next);
            end else if (phase_hit_next && (slen == '0)) begin
                // Phase only: the match runs to the end of the message.
                res_found  = 1'b1;
                res_offset = phase_start_next;
                res_end    = OFF_W'(cnt_next);
            end else if (phase_hit_next && sub_hit_next) begin
                res_found  = 1'b1;
                res_offset = phase_start_next;
                res_end    = sub_end_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic             m_valid_reg;
    logic             m_found_reg;
    logic [OFF_W-1:0] m_offset_reg;
    logic [OFF_W-1:0] m_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_found_reg  <= res_found;
            m_offset_reg <= res_offset;
            m_end_reg    <= res_end;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_phase_offset = m_offset_reg;
    assign m_subphase_end = m_end_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_sub_needs_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        sub_hit_reg |-> phase_hit_reg)
        else $error("subphase hit recorded without a phase hit");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= MSG_MAX + CNT_W'(1))
        else $error("byte count ran past its saturation value");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> (m_offset_reg == '0 && m_end_reg == '0))
        else $error("failed search reported nonzero offsets");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |=> (cnt_reg == '0 && !phase_hit_reg && !sub_hit_reg))
        else $error("message state not cleared after last item");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !res_load)
        else $error("result register loaded while still holding an item");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-stage pattern locator. Streams messages of
// random bytes with phase and subphase patterns woven in, predicts the result
// of each message in step with the accepted items, and compares every result
// item field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import tspl_pkg::*;

    localparam int MAX_PATTERN  = 8;
    localparam int MAX_MESSAGE  = 65535;
    localparam int DRAIN_CYCLES = 6;     // settle time after the queues empty
    localparam int STALL_LIMIT  = 5000;  // cycles with no item moving before giving up
    localparam int LONG_HOLD    = 300;   // receiver hold-off that backs up the block
    localparam int RANDOM_BYTES = 850;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              tail;
    } msg_byte_t;

    typedef struct packed {
        logic             found;
        logic [OFF_W-1:0] phase_offset;
        logic [OFF_W-1:0] subphase_end;
    } locate_result_t;

    typedef enum int {RX_FREE, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_t;

    // ------------------------------------------------------------------------
    // Clock, DUT ports and instance
    // ------------------------------------------------------------------------
    logic                 aclk           = 1'b0;
    logic                 aresetn        = 1'b0;
    logic                 cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index   = CFG_PHASE_PATTERN;
    logic [PAT_W-1:0]     cfg_wr_data    = '0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_src_byte     = '0;
    logic                 s_last         = 1'b0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic                 m_found;
    logic [OFF_W-1:0]     m_phase_offset;
    logic [OFF_W-1:0]     m_subphase_end;

    two_stage_pattern_locator #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_MESSAGE (MAX_MESSAGE)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_index   (cfg_wr_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_src_byte     (s_src_byte),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_phase_offset (m_phase_offset),
        .m_subphase_end (m_subphase_end)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Locator prediction: configuration copy, message state, expected results
    // ------------------------------------------------------------------------
    logic [PAT_W-1:0]  ph_pattern  = '0;
    logic [LEN_W-1:0]  ph_length   = '0;
    logic [PAT_W-1:0]  sub_pattern = '0;
    logic [LEN_W-1:0]  sub_length  = '0;

    logic [BYTE_W-1:0] msg_window [MAX_PATTERN] = '{default: '0};
    int unsigned       msg_count = 0;
    bit                ph_seen   = 1'b0;
    int unsigned       ph_start  = 0;
    bit                sub_seen  = 1'b0;
    int unsigned       sub_end   = 0;

    locate_result_t    expected_locates [$];

    // Stimulus bookkeeping
    msg_byte_t         byte_queue [$];
    logic [BYTE_W-1:0] msg_build [$];
    int unsigned       bytes_queued   = 0;
    int unsigned       bytes_accepted = 0;
    int unsigned       errors         = 0;
    bit                long_hold_req  = 1'b0;

    function automatic void clear_message();
        msg_window = '{default: '0};
        msg_count  = 0;
        ph_seen    = 1'b0;
        ph_start   = 0;
        sub_seen   = 1'b0;
        sub_end    = 0;
    endfunction

    // Pattern byte i of a len-byte match ending at the newest byte sits
    // len-1-i places back in the window.
    function automatic bit window_holds(logic [PAT_W-1:0] pat, int unsigned len);
        int unsigned i;
        for (i = 0; i < len; i++) begin
            if (msg_window[len-1-i] != pat[8*i +: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advance the locator by one accepted byte; on the tail byte queue the
    // result the block owes and start a fresh message.
    task automatic locate_byte(input logic [BYTE_W-1:0] b, input logic is_tail);
        int unsigned    plen;
        int unsigned    slen;
        int unsigned    n;
        int             k;
        bit             had_phase;
        locate_result_t res;
        plen = (ph_length > MAX_PATTERN) ? MAX_PATTERN : ph_length;
        slen = (sub_length > MAX_PATTERN) ? MAX_PATTERN : sub_length;

        for (k = MAX_PATTERN - 1; k > 0; k--)
            msg_window[k] = msg_window[k-1];
        msg_window[0] = b;

        // Saturate one past the limit so an overlong message stays overlong
        if (msg_count <= MAX_MESSAGE)
            msg_count++;
        n = msg_count;

        if (n <= MAX_MESSAGE && plen > 0) begin
            had_phase = ph_seen;
            if (!ph_seen && n >= plen && window_holds(ph_pattern, plen)) begin
                ph_seen  = 1'b1;
                ph_start = n - plen;
            end
            // Subphase must start at or after the end of the phase match
            if (had_phase && !sub_seen && slen > 0 && n >= slen &&
                n - slen >= ph_start + plen && window_holds(sub_pattern, slen)) begin
                sub_seen = 1'b1;
                sub_end  = n;
            end
        end

        if (is_tail) begin
            res = '0;
            if (n <= MAX_MESSAGE) begin
                if (plen == 0) begin
                    res.found        = 1'b1;
                    res.subphase_end = OFF_W'(n);
                end else if (ph_seen && slen == 0) begin
                    res.found        = 1'b1;
                    res.phase_offset = OFF_W'(ph_start);
                    res.subphase_end = OFF_W'(n);
                end else if (ph_seen && sub_seen) begin
                    res.found        = 1'b1;
                    res.phase_offset = OFF_W'(ph_start);
                    res.subphase_end = OFF_W'(sub_end);
                end
            end
            expected_locates.push_back(res);
            clear_message();
        end
    endtask

    // ------------------------------------------------------------------------
    // Input driver: pop pending bytes, send them in bursts with random gaps.
    // Predict at the edge where the handshake completes.
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin : drive_bytes
        msg_byte_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                locate_byte(s_src_byte, s_last);
                bytes_accepted++;
            end
            // Hold the current item until taken; only refill a free slot
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (byte_queue.size() != 0) begin
                    nxt = byte_queue.pop_front();
                    s_valid    <= 1'b1;
                    s_src_byte <= nxt.data;
                    s_last     <= nxt.tail;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // Mix short choppy bursts with long unbroken runs
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(32, 96)
                                                                 : $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor and receiver stall pattern
    // ------------------------------------------------------------------------
    rx_mode_t rx_mode      = RX_FREE;
    int       rx_mode_left = 0;
    int       rx_hold_left = 0;

    task automatic check_field(input string name, input logic [OFF_W-1:0] want,
                               input logic [OFF_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : collect_results
        locate_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_locates.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected result, expected none, actual %0b/%0d/%0d",
                             $time, m_found, m_phase_offset, m_subphase_end);
                end else begin
                    want = expected_locates.pop_front();
                    check_field("found", OFF_W'(want.found), OFF_W'(m_found));
                    check_field("phase_offset", want.phase_offset, m_phase_offset);
                    check_field("subphase_end", want.subphase_end, m_subphase_end);
                end
            end

            // Take a long hold-off when asked, counted here in cycles
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                rx_hold_left  = LONG_HOLD;
            end

            if (rx_mode_left == 0) begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(16, 128);
            end else begin
                rx_mode_left--;
            end

            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_FREE:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
                    RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                    default:   m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if nothing moves for too long
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge aclk) begin : watchdog
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic is_tail);
        byte_queue.push_back('{data: b, tail: is_tail});
        bytes_queued++;
    endtask

    // Wait until every queued byte is taken and every result has come, then
    // let the pipeline settle on any byte that owes no result.
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (bytes_accepted != bytes_queued || expected_locates.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        case (idx)
            CFG_PHASE_PATTERN:    ph_pattern  = value;
            CFG_PHASE_LENGTH:     ph_length   = value[LEN_W-1:0];
            CFG_SUBPHASE_PATTERN: sub_pattern = value;
            CFG_SUBPHASE_LENGTH:  sub_length  = value[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Length writes carry junk above the low nibble; only the nibble counts
    task automatic apply_config(input logic [PAT_W-1:0] pp, input logic [LEN_W-1:0] pl,
                                input logic [PAT_W-1:0] sp, input logic [LEN_W-1:0] sl);
        logic [PAT_W-1:0] word;
        write_reg(CFG_PHASE_PATTERN, pp);
        word = {$urandom, $urandom};
        word[LEN_W-1:0] = pl;
        write_reg(CFG_PHASE_LENGTH, word);
        write_reg(CFG_SUBPHASE_PATTERN, sp);
        word = {$urandom, $urandom};
        word[LEN_W-1:0] = sl;
        write_reg(CFG_SUBPHASE_LENGTH, word);
        end_writes();
    endtask

    function automatic logic [BYTE_W-1:0] alpha_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h5A;
            default: return 8'hA5;
        endcase
    endfunction

    // Noise leans on pattern bytes so near misses and overlaps show up often
    function automatic logic [BYTE_W-1:0] noise_byte();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        case ($urandom_range(0, 3))
            0:       return ph_pattern[8*sel +: 8];
            1:       return sub_pattern[8*sel +: 8];
            2:       return alpha_byte();
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return LEN_W'($urandom_range(MAX_PATTERN + 1, 15));
            2:       return LEN_W'(MAX_PATTERN);
            default: return LEN_W'($urandom_range(1, MAX_PATTERN));
        endcase
    endfunction

    task automatic random_config();
        logic [PAT_W-1:0] pp;
        logic [PAT_W-1:0] sp;
        bit               narrow;
        int               i;
        narrow = ($urandom_range(0, 1) == 1);
        for (i = 0; i < MAX_PATTERN; i++) begin
            pp[8*i +: 8] = narrow ? alpha_byte() : BYTE_W'($urandom_range(0, 255));
            sp[8*i +: 8] = narrow ? alpha_byte() : BYTE_W'($urandom_range(0, 255));
        end
        apply_config(pp, pick_length(), sp, pick_length());
    endtask

    task automatic add_noise(input int max_count);
        repeat ($urandom_range(0, max_count)) msg_build.push_back(noise_byte());
    endtask

    // Append a pattern copy, now and then cut short to break the sequence
    task automatic add_pattern(input logic [PAT_W-1:0] pat, input logic [LEN_W-1:0] len_reg);
        int unsigned len;
        int unsigned cut;
        int unsigned i;
        len = (len_reg > MAX_PATTERN) ? MAX_PATTERN : len_reg;
        cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len) : len;
        for (i = 0; i < cut; i++)
            msg_build.push_back(pat[8*i +: 8]);
    endtask

    // Build one message: noise, phase, noise, subphase, noise, or subphase and phase
    // swapped. Leave it open when close is clear so the next phase continues it.
    task automatic queue_message(input bit close);
        int i;
        msg_build.delete();
        add_noise(6);
        if ($urandom_range(0, 4) == 0) begin
            // Subphase ahead of the phase must not count
            add_pattern(sub_pattern, sub_length);
            add_noise(3);
            add_pattern(ph_pattern, ph_length);
        end else begin
            if ($urandom_range(0, 4) != 0)
                add_pattern(ph_pattern, ph_length);
            add_noise(4);
            if ($urandom_range(0, 4) != 0)
                add_pattern(sub_pattern, sub_length);
        end
        add_noise(4);
        if (msg_build.size() == 0)
            msg_build.push_back(noise_byte());
        for (i = 0; i < msg_build.size(); i++)
            queue_byte(msg_build[i], close && (i == msg_build.size() - 1));
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : run_test
        bit hold_done;
        hold_done = 1'b0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // No phase configured after reset: whole message accepted
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b1);
        wait_idle();

        // Oversized all-zero phase: stale window bytes must not fake an early match
        apply_config('0, 4'd15, '0, 4'd0);
        repeat (7) queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b1);
        wait_idle();

        // Phase then subphase, and subphase ahead of the phase
        apply_config(64'hFFFF_FFFF_FFFF_5AA5, 4'd2, '1, 4'd1);
        queue_byte(8'h5A, 1'b0);
        queue_byte(8'hA5, 1'b0);
        queue_byte(8'h5A, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hA5, 1'b0);
        queue_byte(8'h5A, 1'b1);
        wait_idle();

        // Phase only, then arm the subphase in the middle of a message
        apply_config(64'h0000_0000_0000_00A5, 4'd1, '0, 4'd0);
        queue_byte(8'hA5, 1'b0);
        wait_idle();
        write_reg(CFG_SUBPHASE_PATTERN, 64'h0000_0000_0000_003C);
        write_reg(CFG_SUBPHASE_LENGTH, 64'd1);
        end_writes();
        queue_byte(8'h3C, 1'b1);
        wait_idle();

        // Random phases: new settings, a handful of messages, sometimes one
        // left open across the next register writes
        while (bytes_queued < RANDOM_BYTES) begin
            wait_idle();
            random_config();
            if (!hold_done && bytes_queued > RANDOM_BYTES / 2) begin
                // Back the block up: hold the receiver, flood one-byte messages
                hold_done     = 1'b1;
                long_hold_req = 1'b1;
                repeat (60) queue_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
            end
            repeat ($urandom_range(1, 6)) queue_message(1'b1);
            if ($urandom_range(0, 3) == 0)
                queue_message(1'b0);
        end
        wait_idle();

        // Full-length patterns; close out any message left open
        apply_config(64'h8877_6655_4433_2211, 4'd8, 64'hF0E0_D0C0_B0A0_9080, 4'd8);
        queue_message(1'b1);
        wait_idle();

        if (errors == 0 && expected_locates.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### two_stage_pattern_locator.f
rtl/tspl_pkg.sv
rtl/tspl_window_match.sv
rtl/two_stage_pattern_locator.sv
tb/tb.sv
